[design/difference_blend_yuv_pixel_assert.svh]
// ---------------------------------------------------------------------------
// Difference blend assertion macros
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DIFFERENCE_BLEND_YUV_PIXEL_ASSERT_SVH
`define DIFFERENCE_BLEND_YUV_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBY_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("difference blend assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DBY_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("difference blend assertion failed");

`endif

[design/dby_pkg.sv]
// ---------------------------------------------------------------------------
// Difference blend package
// Shared widths, register codes and the configuration bundle for the lanes.
// ---------------------------------------------------------------------------
package dby_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int BITS_W      = 5;
  localparam int MIN_BITS    = 8;
  localparam int LANE_STAGES = 5;

  typedef enum logic [1:0] {
    REG_PIXEL_BITS = 2'd0,
    REG_OPACITY    = 2'd1,
    REG_MASK_EN    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [BITS_W-1:0]   bits;
    logic [BITS_W-1:0]   shift;
    logic [SAMPLE_W-1:0] maxv;
    logic [SAMPLE_W-1:0] half;
    logic [SAMPLE_W-1:0] step;
    logic [SAMPLE_W-1:0] opac;
    logic                mask_en;
  } blend_cfg_t;

endpackage

[design/dby_if.sv]
// ---------------------------------------------------------------------------
// Difference blend channel interfaces
// Valid/ready channels for the pixel request and the blended pixel result.
// ---------------------------------------------------------------------------
interface dby_in_if import dby_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] base_luma;
  logic [SAMPLE_W-1:0] base_cb;
  logic [SAMPLE_W-1:0] base_cr;
  logic [SAMPLE_W-1:0] over_luma;
  logic [SAMPLE_W-1:0] over_cb;
  logic [SAMPLE_W-1:0] over_cr;
  logic [SAMPLE_W-1:0] mask_luma;
  logic [SAMPLE_W-1:0] mask_cb;
  logic [SAMPLE_W-1:0] mask_cr;

  modport source (
    output valid, base_luma, base_cb, base_cr, over_luma, over_cb, over_cr,
           mask_luma, mask_cb, mask_cr,
    input  ready
  );
  modport sink (
    input  valid, base_luma, base_cb, base_cr, over_luma, over_cb, over_cr,
           mask_luma, mask_cb, mask_cr,
    output ready
  );
endinterface

interface dby_out_if import dby_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] out_luma;
  logic [SAMPLE_W-1:0] out_cb;
  logic [SAMPLE_W-1:0] out_cr;

  modport source (output valid, out_luma, out_cb, out_cr, input ready);
  modport sink (input valid, out_luma, out_cb, out_cr, output ready);
endinterface

[design/dby_lane.sv]
// ---------------------------------------------------------------------------
// Difference blend lane
// Five-stage datapath for one channel: difference, effective weight,
// blend products, rounding sum and division by the pixel maximum.
// ---------------------------------------------------------------------------
module dby_lane import dby_pkg::*; #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  blend_cfg_t             cfg,
  input  logic [SAMPLE_W-1:0]    base,
  input  logic [SAMPLE_W-1:0]    over,
  input  logic [SAMPLE_W-1:0]    mask,
  output logic [W:0]             blend
);

  localparam int XW = 2 * W + 1;

  // Division by 2^n - 1: fold the high part onto the low part, then the
  // quotient needs at most two increments for the value ranges seen here.
  function automatic logic [XW-1:0] div_max(input logic [XW-1:0] x,
                                            input logic [BITS_W-1:0] n,
                                            input logic [W-1:0] m);
    logic [XW-1:0] mx;
    logic [XW-1:0] a;
    logic [XW-1:0] c;
    logic [XW-1:0] s;
    mx = XW'(m);
    a  = x >> n;
    c  = x & mx;
    s  = a + c;
    if (s >= (mx << 1)) begin
      return a + XW'(2);
    end else if (s >= mx) begin
      return a + XW'(1);
    end else begin
      return a;
    end
  endfunction

  function automatic logic [W-1:0] sat_in(input logic [SAMPLE_W-1:0] v,
                                          input logic [SAMPLE_W-1:0] m);
    return (v > m) ? m[W-1:0] : v[W-1:0];
  endfunction

  logic [W-1:0]  maxv;
  logic [W-1:0]  rnd;
  logic [W-1:0]  b_s;
  logic [W-1:0]  o_s;
  logic [W-1:0]  m_s;
  logic [W-1:0]  absd;

  logic [W:0]    diff_a_r;
  logic [W-1:0]  b_a_r;
  logic [XW-1:0] pm_a_r;
  logic [W:0]    diff_b_r;
  logic [W-1:0]  b_b_r;
  logic [W-1:0]  eff_b_r;
  logic [XW-1:0] p1_c_r;
  logic [XW-1:0] p2_c_r;
  logic [XW-1:0] x_d_r;
  logic [W:0]    y_e_r;
  logic [XW-1:0] eff_q;
  logic [XW-1:0] y_q;

  always_comb begin
    maxv  = cfg.maxv[W-1:0];
    rnd   = maxv >> 1;
    b_s   = sat_in(base, cfg.maxv);
    o_s   = sat_in(over, cfg.maxv);
    m_s   = sat_in(mask, cfg.maxv);
    absd  = (b_s > o_s) ? (b_s - o_s) : (o_s - b_s);
    eff_q = div_max(pm_a_r + XW'(rnd), cfg.bits, maxv);
    y_q   = div_max(x_d_r, cfg.bits, maxv);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_a_r <= (W+1)'(absd) + (W+1)'(cfg.half[W-1:0]);
      b_a_r    <= b_s;
      pm_a_r   <= XW'(m_s) * XW'(cfg.opac[W-1:0]);
    end
    if (en[1]) begin
      diff_b_r <= diff_a_r;
      b_b_r    <= b_a_r;
      eff_b_r  <= cfg.mask_en ? eff_q[W-1:0] : cfg.opac[W-1:0];
    end
    if (en[2]) begin
      p1_c_r <= XW'(diff_b_r) * XW'(eff_b_r);
      p2_c_r <= XW'(maxv - eff_b_r) * XW'(b_b_r);
    end
    if (en[3]) begin
      x_d_r <= p1_c_r + p2_c_r + XW'(rnd);
    end
    if (en[4]) begin
      y_e_r <= y_q[W:0];
    end
  end

  assign blend = y_e_r;

endmodule

[design/dby_merge.sv]
// ---------------------------------------------------------------------------
// Difference blend merge stage
// Combines the three lanes: overbright pull of chroma toward grey, luma
// clamp and final chroma clamp, ending in the output register.
// ---------------------------------------------------------------------------
module dby_merge import dby_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic [1:0]          en,
  input  blend_cfg_t          cfg,
  input  logic [W:0]          y_in,
  input  logic [W:0]          u_in,
  input  logic [W:0]          v_in,
  output logic [SAMPLE_W-1:0] out_luma,
  output logic [SAMPLE_W-1:0] out_cb,
  output logic [SAMPLE_W-1:0] out_cr
);

  localparam int PW = 2 * W;

  function automatic logic [W-1:0] sat_res(input logic [PW-1:0] v,
                                           input logic [W-1:0] m);
    return (v > PW'(m)) ? m : v[W-1:0];
  endfunction

  logic [W-1:0]  maxv;
  logic [W-3:0]  step_w;
  logic [W:0]    top_w;
  logic [W:0]    m_full;
  logic [W-3:0]  m_w;
  logic          ovr;
  logic [PW-1:0] su;
  logic [PW-1:0] sv;
  logic [PW-1:0] uc;
  logic [PW-1:0] vc;

  logic          ovr_f_r;
  logic [W-1:0]  y_f_r;
  logic [W:0]    u_f_r;
  logic [W:0]    v_f_r;
  logic [PW-1:0] pu_f_r;
  logic [PW-1:0] pv_f_r;
  logic [PW-1:0] h_f_r;
  logic [SAMPLE_W-1:0] luma_r;
  logic [SAMPLE_W-1:0] cb_r;
  logic [SAMPLE_W-1:0] cr_r;

  always_comb begin
    maxv   = cfg.maxv[W-1:0];
    step_w = cfg.step[W-3:0];
    top_w  = (W+1)'(maxv) + (W+1)'(step_w) + (W+1)'(1);
    ovr    = y_in > (W+1)'(maxv);
    m_full = (y_in < top_w) ? (top_w - y_in) : '0;
    m_w    = m_full[W-3:0];
    su     = (pu_f_r + h_f_r) >> cfg.shift;
    sv     = (pv_f_r + h_f_r) >> cfg.shift;
    uc     = ovr_f_r ? su : PW'(u_f_r);
    vc     = ovr_f_r ? sv : PW'(v_f_r);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ovr_f_r <= ovr;
      y_f_r   <= y_in[W-1:0];
      u_f_r   <= u_in;
      v_f_r   <= v_in;
      pu_f_r  <= PW'(u_in) * PW'(m_w);
      pv_f_r  <= PW'(v_in) * PW'(m_w);
      h_f_r   <= PW'(step_w - m_w) << (cfg.bits - BITS_W'(1));
    end
    if (en[1]) begin
      luma_r <= SAMPLE_W'(ovr_f_r ? maxv : y_f_r);
      cb_r   <= SAMPLE_W'(sat_res(uc, maxv));
      cr_r   <= SAMPLE_W'(sat_res(vc, maxv));
    end
  end

  assign out_luma = luma_r;
  assign out_cb   = cb_r;
  assign out_cr   = cr_r;

endmodule

[design/difference_blend_yuv_pixel.sv]
// ---------------------------------------------------------------------------
// Difference blend of one YUV pixel
// A request passes the lane stages, then the merge stages, to the output.
// Throughput: one pixel per cycle unless the output stalls, set by the three
// fully pipelined lanes and the two-stage merge; each stage moves on as soon as
// its successor frees. Reset: rst_n clears all stage valid bits and loads
// pixel_bits 8, opacity 65535 and mask disabled; data registers are not reset.
// ---------------------------------------------------------------------------
`include "difference_blend_yuv_pixel_assert.svh"

module difference_blend_yuv_pixel import dby_pkg::*; #(
  parameter int MAX_PIXEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  dby_in_if.sink              in_pix,
  dby_out_if.source           out_pix,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  localparam int NST = LANE_STAGES + 2;

  logic [BITS_W-1:0]   pixel_bits_r;
  logic [SAMPLE_W-1:0] opacity_r;
  logic                mask_en_r;

  logic [BITS_W-1:0]   bits_c;
  logic [SAMPLE_W:0]   pow;
  logic [SAMPLE_W:0]   maxv_full;
  blend_cfg_t          cfg;

  logic [NST-1:0]      vld_r;
  logic [NST-1:0]      en;

  logic [MAX_PIXEL_BITS:0] y_l;
  logic [MAX_PIXEL_BITS:0] u_l;
  logic [MAX_PIXEL_BITS:0] v_l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bits_r <= BITS_W'(MIN_BITS);
      opacity_r    <= '1;
      mask_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_PIXEL_BITS: pixel_bits_r <= cfg_data[BITS_W-1:0];
        REG_OPACITY:    opacity_r    <= cfg_data;
        REG_MASK_EN:    mask_en_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (pixel_bits_r < BITS_W'(MIN_BITS)) begin
      bits_c = BITS_W'(MIN_BITS);
    end else if (pixel_bits_r > BITS_W'(MAX_PIXEL_BITS)) begin
      bits_c = BITS_W'(MAX_PIXEL_BITS);
    end else begin
      bits_c = pixel_bits_r;
    end
    pow         = {{SAMPLE_W{1'b0}}, 1'b1} << bits_c;
    maxv_full   = pow - (SAMPLE_W+1)'(1);
    cfg.bits    = bits_c;
    cfg.shift   = bits_c - BITS_W'(3);
    cfg.maxv    = maxv_full[SAMPLE_W-1:0];
    cfg.half    = pow[SAMPLE_W:1];
    cfg.step    = SAMPLE_W'(pow[SAMPLE_W:3]);
    cfg.opac    = (opacity_r > maxv_full[SAMPLE_W-1:0]) ? maxv_full[SAMPLE_W-1:0]
                                                        : opacity_r;
    cfg.mask_en = mask_en_r;
  end

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_pix.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          vld_r[i] <= (i == 0) ? in_pix.valid : vld_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_pix.ready  = en[0];
  assign out_pix.valid = vld_r[NST-1];

  dby_lane #(.W(MAX_PIXEL_BITS)) u_lane_y (
    .clk   (clk),
    .en    (en[LANE_STAGES-1:0]),
    .cfg   (cfg),
    .base  (in_pix.base_luma),
    .over  (in_pix.over_luma),
    .mask  (in_pix.mask_luma),
    .blend (y_l)
  );

  dby_lane #(.W(MAX_PIXEL_BITS)) u_lane_u (
    .clk   (clk),
    .en    (en[LANE_STAGES-1:0]),
    .cfg   (cfg),
    .base  (in_pix.base_cb),
    .over  (in_pix.over_cb),
    .mask  (in_pix.mask_cb),
    .blend (u_l)
  );

  dby_lane #(.W(MAX_PIXEL_BITS)) u_lane_v (
    .clk   (clk),
    .en    (en[LANE_STAGES-1:0]),
    .cfg   (cfg),
    .base  (in_pix.base_cr),
    .over  (in_pix.over_cr),
    .mask  (in_pix.mask_cr),
    .blend (v_l)
  );

  dby_merge #(.W(MAX_PIXEL_BITS)) u_merge (
    .clk      (clk),
    .en       (en[NST-1:LANE_STAGES]),
    .cfg      (cfg),
    .y_in     (y_l),
    .u_in     (u_l),
    .v_in     (v_l),
    .out_luma (out_pix.out_luma),
    .out_cb   (out_pix.out_cb),
    .out_cr   (out_pix.out_cr)
  );

  // With the output register empty, every stage can move, so a request is taken.
  `DBY_ASSERT_IMP(a_ready_when_out_empty, !out_pix.valid, in_pix.ready)
  // A taken result with nothing in the first merge stage leaves the output empty.
  `DBY_ASSERT_NXT(a_drain_empty, out_pix.valid && out_pix.ready && !vld_r[NST-2],
                  !out_pix.valid)

endmodule
